// ===== src/vkb_pkg.sv =====
// Package for the viseme keyframe blender: widths, codes, phoneme weight table.
// No dependencies.
package vkb_pkg;
    localparam int MaxKeysDefault = 64;
    localparam logic [15:0] SeqLenReset = 16'hFFFF;
    localparam logic [15:0] QOne = 16'd4096;

    typedef enum logic [1:0] {OP_CLEAR = 2'd0, OP_APPEND = 2'd1, OP_EVAL = 2'd2,
                              OP_NOP = 2'd3} op_t;
    localparam logic [1:0] ST_OK = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    typedef struct packed {
        logic clear;
        logic append;
        logic eval_start;
        logic rd_en;
        logic idx_inc;
        logic load_prev_implicit;
        logic load_prev_mem;
        logic load_next_implicit;
        logic load_next_mem;
        logic div_start;
        logic chan_start;
        logic chan_step;
        logic out_load;
        logic [1:0] out_status;
    } vkb_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
        logic first_lt;
        logic match;
        logic last_idx;
        logic div_done;
        logic chan_done;
    } vkb_sts_t;

    function automatic logic [12:0] weight_of(input logic [3:0] code, input logic [2:0] ch);
        logic [3:0] c;
        logic [12:0] w;
        begin
            c = (code > 4'd12) ? 4'd12 : code;
            w = 13'd0;
            case (c)
                4'd1: w = (ch == 3'd0) ? 13'd4096 : 13'd0;
                4'd2: w = (ch == 3'd1) ? 13'd4096 : 13'd0;
                4'd3: w = (ch == 3'd2) ? 13'd4096 : 13'd0;
                4'd4: w = (ch == 3'd2) ? 13'd1229 : 13'd0;
                4'd5: w = (ch == 3'd3) ? 13'd4096 : 13'd0;
                4'd6: w = (ch == 3'd4) ? 13'd4096 : 13'd0;
                4'd7: w = (ch == 3'd0) ? 13'd410 :
                          ((ch == 3'd1 || ch == 3'd4) ? 13'd1229 : 13'd0);
                4'd8: w = (ch == 3'd2) ? 13'd2048 : 13'd0;
                4'd9: w = (ch == 3'd1 || ch == 3'd3) ? 13'd1229 : 13'd0;
                4'd10: w = (ch == 3'd1) ? 13'd1229 :
                           ((ch == 3'd3 || ch == 3'd4) ? 13'd819 : 13'd0);
                4'd11: w = (ch == 3'd1) ? 13'd819 : ((ch == 3'd3) ? 13'd410 : 13'd0);
                4'd12: w = (ch == 3'd0 || ch == 3'd1) ? 13'd1229 : 13'd0;
                default: w = 13'd0;
            endcase
            return w;
        end
    endfunction
endpackage

// ===== src/vkb_ram.sv =====
// Generic simple dual-port RAM (one write port, one read port) with registered read.
// No dependencies.
module vkb_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end
endmodule

// ===== src/vkb_datapath.sv =====
// Datapath: keyframe RAM, count, bracket registers, serial divider, blend MAC.
// Depends on vkb_pkg and vkb_ram.
module vkb_datapath #(
    parameter int MAX_KEYS = vkb_pkg::MaxKeysDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  vkb_pkg::vkb_cmd_t cmd,
    output vkb_pkg::vkb_sts_t sts,
    input  logic [15:0]       seq_len,
    input  logic [15:0]       key_time_in,
    input  logic [3:0]        key_code_in,
    input  logic [15:0]       key_strength_in,
    input  logic [15:0]       position,
    output logic [1:0]        status,
    output logic [79:0]       weights
);
    import vkb_pkg::*;

    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);

    logic [CW-1:0] count_reg;
    logic [AW-1:0] idx_reg;
    logic [35:0]   rdata;
    logic [15:0]   tp_reg, sp_reg, tn_reg, sn_reg;
    logic [3:0]    cp_reg, cn_reg;
    logic [15:0]   pos_reg;
    logic [16:0]   den_reg;
    logic [16:0]   rem_reg;
    logic [15:0]   q_reg;
    logic          fz_reg, fsat_reg;
    logic [4:0]    dcnt_reg;
    logic          dbusy_reg;
    logic [16:0]   f_reg;
    logic [2:0]    ch_reg;
    logic [1:0]    cph_reg;
    logic [28:0]   s0_reg, s1_reg;
    logic [46:0]   acc_reg;
    logic [79:0]   w_reg;
    logic [1:0]    st_reg;

    logic [15:0] rt;
    assign rt = rdata[35:20];

    vkb_ram #(.WIDTH(36), .DEPTH(MAX_KEYS)) u_ram (
        .clk(clk), .we(cmd.append && !sts.full), .waddr(count_reg[AW-1:0]),
        .wdata({key_time_in, key_code_in, key_strength_in}),
        .re(cmd.rd_en), .raddr(idx_reg), .rdata(rdata)
    );

    assign sts.empty = (count_reg == '0);
    assign sts.full = (count_reg == CW'(MAX_KEYS));
    assign sts.first_lt = rt < pos_reg;
    assign sts.match = (tp_reg <= pos_reg) && (pos_reg <= rt);
    assign sts.last_idx = (CW'(idx_reg) + CW'(1)) >= count_reg;
    assign sts.div_done = dbusy_reg && (dcnt_reg == 5'd0);
    assign sts.chan_done = (ch_reg == 3'd4) && (cph_reg == 2'd3);

    logic signed [17:0] nsg, dsg;
    assign nsg = $signed({2'b0, pos_reg}) - $signed({2'b0, tp_reg});
    assign dsg = $signed({2'b0, tn_reg}) - $signed({2'b0, tp_reg});

    logic [16:0] nabs, dabs;
    logic        frac_zero;
    assign nabs = nsg[17] ? 17'(-nsg) : 17'(nsg);
    assign dabs = dsg[17] ? 17'(-dsg) : 17'(dsg);
    assign frac_zero = (dsg == '0) || (nsg == '0) || (nsg[17] != dsg[17]);

    logic [16:0] trial;
    assign trial = {rem_reg[15:0], 1'b0};

    logic [46:0] rnd;
    assign rnd = (acc_reg + 47'(1 << 27)) >> 28;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            dbusy_reg <= 1'b0;
            dcnt_reg <= '0;
            cph_reg <= '0;
            ch_reg <= '0;
        end
        else
        begin
            if (cmd.clear)
            begin
                count_reg <= '0;
            end
            else if (cmd.append && !sts.full)
            begin
                count_reg <= count_reg + CW'(1);
            end
            if (cmd.div_start)
            begin
                dbusy_reg <= 1'b1;
                dcnt_reg <= 5'd16;
            end
            else if (dbusy_reg)
            begin
                if (dcnt_reg == 5'd0)
                begin
                    dbusy_reg <= 1'b0;
                end
                else
                begin
                    dcnt_reg <= dcnt_reg - 5'd1;
                end
            end
            if (cmd.chan_start)
            begin
                ch_reg <= '0;
                cph_reg <= '0;
            end
            else if (cmd.chan_step)
            begin
                cph_reg <= cph_reg + 2'd1;
                if (cph_reg == 2'd3)
                begin
                    ch_reg <= ch_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.eval_start)
        begin
            pos_reg <= position;
        end
        if (cmd.eval_start)
        begin
            idx_reg <= '0;
        end
        else if (cmd.idx_inc)
        begin
            idx_reg <= idx_reg + AW'(1);
        end
        if (cmd.load_prev_implicit)
        begin
            tp_reg <= '0;
            cp_reg <= '0;
            sp_reg <= QOne;
        end
        else if (cmd.load_prev_mem)
        begin
            tp_reg <= rt;
            cp_reg <= rdata[19:16];
            sp_reg <= rdata[15:0];
        end
        if (cmd.load_next_implicit)
        begin
            tn_reg <= seq_len;
            cn_reg <= '0;
            sn_reg <= QOne;
        end
        else if (cmd.load_next_mem)
        begin
            tn_reg <= rt;
            cn_reg <= rdata[19:16];
            sn_reg <= rdata[15:0];
        end
        if (cmd.div_start)
        begin
            rem_reg <= nabs;
            den_reg <= dabs;
            q_reg <= '0;
            fz_reg <= frac_zero;
            fsat_reg <= (nabs >= dabs);
        end
        else if (dbusy_reg && dcnt_reg != 5'd0)
        begin
            // shift in one quotient bit per cycle
            if (trial >= den_reg)
            begin
                rem_reg <= trial - den_reg;
                q_reg <= {q_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                q_reg <= {q_reg[14:0], 1'b0};
            end
        end
        if (sts.div_done)
        begin
            f_reg <= fz_reg ? 17'd0 : (fsat_reg ? 17'h10000 : {1'b0, q_reg});
        end
        if (cmd.chan_step)
        begin
            case (cph_reg)
                2'd0:
                begin
                    s0_reg <= 29'(weight_of(cp_reg, ch_reg)) * 29'(sp_reg);
                    s1_reg <= 29'(weight_of(cn_reg, ch_reg)) * 29'(sn_reg);
                end
                2'd1: acc_reg <= 47'(s0_reg) * 47'(17'h10000 - f_reg);
                2'd2: acc_reg <= acc_reg + 47'(s1_reg) * 47'(f_reg);
                default: acc_reg <= acc_reg;
            endcase
        end
        if (cmd.out_load)
        begin
            st_reg <= cmd.out_status;
        end
        if (cmd.chan_start || (cmd.out_load && !cmd.chan_step))
        begin
            w_reg <= '0;
        end
        else if (cmd.chan_step && cph_reg == 2'd3)
        begin
            w_reg[16*ch_reg +: 16] <= (rnd > 47'hFFFF) ? 16'hFFFF : rnd[15:0];
        end
    end

    assign status = st_reg;
    assign weights = w_reg;
endmodule

// ===== src/vkb_ctrl.sv =====
// Controller state machine: answers clear, append and no-op, and sequences search, division and blend for evaluate.
// Depends on vkb_pkg.
module vkb_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        op,
    output logic              out_valid,
    input  logic              out_ready,
    output vkb_pkg::vkb_cmd_t cmd,
    input  vkb_pkg::vkb_sts_t sts
);
    import vkb_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE = 8'b00000001, S_RD0 = 8'b00000010, S_CHK0 = 8'b00000100,
        S_RDP = 8'b00001000, S_CMP = 8'b00010000, S_DIV = 8'b00100000,
        S_BLEND = 8'b01000000, S_OUT = 8'b10000000
    } state_t;

    state_t state_reg, state_next;
    logic ov_reg, ov_next;

    assign in_ready = (state_reg == S_IDLE) && !ov_reg;
    assign out_valid = ov_reg;

    always_comb
    begin
        cmd = '0;
        state_next = state_reg;
        ov_next = ov_reg && !out_ready;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    case (op_t'(op))
                        OP_CLEAR:
                        begin
                            cmd.clear = 1'b1;
                            cmd.out_load = 1'b1;
                            ov_next = 1'b1;
                        end
                        OP_APPEND:
                        begin
                            cmd.append = 1'b1;
                            cmd.out_load = 1'b1;
                            cmd.out_status = sts.full ? ST_FULL : ST_OK;
                            ov_next = 1'b1;
                        end
                        OP_EVAL:
                        begin
                            if (sts.empty)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_status = ST_EMPTY;
                                ov_next = 1'b1;
                            end
                            else
                            begin
                                cmd.eval_start = 1'b1;
                                state_next = S_RD0;
                            end
                        end
                        default:
                        begin
                            cmd.out_load = 1'b1;
                            cmd.out_status = ST_OK;
                            ov_next = 1'b1;
                        end
                    endcase
                end
            end
            S_RD0:
            begin
                cmd.rd_en = 1'b1;
                cmd.load_prev_implicit = 1'b1;
                state_next = S_CHK0;
            end
            S_CHK0:
            begin
                if (!sts.first_lt)
                begin
                    cmd.load_next_mem = 1'b1;
                    state_next = S_DIV;
                end
                else if (sts.last_idx)
                begin
                    cmd.load_prev_mem = 1'b1;
                    cmd.load_next_implicit = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    cmd.load_prev_mem = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next = S_RDP;
                end
            end
            S_RDP:
            begin
                cmd.rd_en = 1'b1;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (sts.match)
                begin
                    cmd.load_next_mem = 1'b1;
                    state_next = S_DIV;
                end
                else if (sts.last_idx)
                begin
                    cmd.load_prev_mem = 1'b1;
                    cmd.load_next_implicit = 1'b1;
                    state_next = S_DIV;
                end
                else
                begin
                    cmd.load_prev_mem = 1'b1;
                    cmd.idx_inc = 1'b1;
                    state_next = S_RDP;
                end
            end
            S_DIV:
            begin
                cmd.div_start = 1'b1;
                cmd.chan_start = 1'b1;
                state_next = S_BLEND;
            end
            S_BLEND:
            begin
                if (sts.div_done)
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                cmd.chan_step = 1'b1;
                if (sts.chan_done)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_status = ST_OK;
                    ov_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg <= ov_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) ov_reg |-> state_reg == S_IDLE)
        else $error("result held while busy");
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
    assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && !out_ready) |=> ov_reg)
        else $error("result dropped");
endmodule

// ===== src/viseme_keyframe_blender_unit.sv =====
// Viseme keyframe blender: keyframe table with interpolated mouth weights.
// Uses a keyframe RAM with registered read; one word in, one word out per item.
// Slave stream s_axis carries operation and keyframe/position fields; master
// stream m_axis carries status and five Q4.12 weights. One item is taken at a
// time: the input is ready only while the block is idle and its result word
// has been taken. Clear, append and no-op answer one cycle after acceptance.
// Evaluate reads the first keyframe, then one RAM read per further keyframe
// visited, starts the divider, runs a bit-serial divider for the fraction and
// then blends with multiply-accumulate steps shared over the five channels.
// The next word is taken the cycle after the result word is taken. A stalled
// receiver holds the result and the input stays not ready. Reset clears the
// keyframe count and sets sequence_length to its maximum; the RAM itself is
// not cleared. The user must see that sequence_length is written over APB at
// address 0 only while idle; the block itself does not enforce it.
module viseme_keyframe_blender_unit #(
    parameter int MAX_KEYS = vkb_pkg::MaxKeysDefault
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // operation[1:0], key_time_in[17:2], key_code_in[21:18],
    // key_strength_in[37:22], position[53:38]
    input  logic [55:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0], weight_a[17:2], weight_e[33:18], weight_ae[49:34],
    // weight_o[65:50], weight_f[81:66]
    output logic [87:0] m_axis_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic        paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import vkb_pkg::*;

    vkb_cmd_t cmd;
    vkb_sts_t sts;
    logic [15:0] seq_len_reg;
    logic [1:0] status;
    logic [79:0] weights;

    assign pready = 1'b1;
    assign prdata = (paddr == 1'b0) ? {16'd0, seq_len_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_len_reg <= SeqLenReset;
        end
        else if (psel && penable && pwrite && paddr == 1'b0)
        begin
            seq_len_reg <= pwdata[15:0];
        end
    end

    vkb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .op(s_axis_tdata[1:0]), .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .cmd(cmd), .sts(sts)
    );

    vkb_datapath #(.MAX_KEYS(MAX_KEYS)) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .seq_len(seq_len_reg),
        .key_time_in(s_axis_tdata[17:2]), .key_code_in(s_axis_tdata[21:18]),
        .key_strength_in(s_axis_tdata[37:22]), .position(s_axis_tdata[53:38]),
        .status(status), .weights(weights)
    );

    assign m_axis_tdata = {6'd0, weights, status};
endmodule

// ===== test/viseme_keyframe_blender_unit_tb.sv =====
// Self-checking bench for viseme_keyframe_blender_unit: stream words in, blended weights out.
// Holds its own keyframe table and blend arithmetic; needs vkb_pkg and the unit only.
module viseme_keyframe_blender_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import vkb_pkg::*;

    localparam int KeyDepth = MaxKeysDefault;
    localparam int StallLimit = 5000;
    localparam int unsigned MouthWeight [13][5] = '{
        '{0, 0, 0, 0, 0},
        '{4096, 0, 0, 0, 0},
        '{0, 4096, 0, 0, 0},
        '{0, 0, 4096, 0, 0},
        '{0, 0, 1229, 0, 0},
        '{0, 0, 0, 4096, 0},
        '{0, 0, 0, 0, 4096},
        '{410, 1229, 0, 0, 1229},
        '{0, 0, 2048, 0, 0},
        '{0, 1229, 0, 1229, 0},
        '{0, 1229, 0, 819, 819},
        '{0, 819, 0, 410, 0},
        '{1229, 1229, 0, 0, 0}
    };

    class blend_scoreboard;
        logic [15:0] seq_len;
        logic [15:0] key_time [KeyDepth];
        logic [3:0]  key_code [KeyDepth];
        logic [15:0] key_str [KeyDepth];
        int          key_count;
        logic [87:0] blend_q [$];
        int          errors;

        function new();
            seq_len = SeqLenReset;
            key_count = 0;
            errors = 0;
        endfunction

        function longint unsigned fraction(longint pos, longint tp, longint tn);
            longint num;
            longint den;
            longint unsigned q;
            num = pos - tp;
            den = tn - tp;
            if (den == 0 || num == 0) return 0;
            if ((num < 0) != (den < 0)) return 0;
            if (num < 0)
            begin
                num = -num;
                den = -den;
            end
            q = (longint'(num) * 65536) / den;
            return (q > 65536) ? 65536 : q;
        endfunction

        function void note_item(logic [55:0] w);
            op_t op;
            logic [15:0] ktime, kstr, pos;
            logic [3:0] kcode;
            logic [1:0] status;
            logic [15:0] wt [5];
            logic [87:0] exp_word;
            int t, ch, cp, cn;
            longint unsigned tp, sp, tn, sn, f, s0, s1, acc, r;
            op = op_t'(w[1:0]);
            ktime = w[17:2];
            kcode = w[21:18];
            kstr = w[37:22];
            pos = w[53:38];
            status = ST_OK;
            for (ch = 0; ch < 5; ch++) wt[ch] = '0;
            if (op == OP_CLEAR)
                key_count = 0;
            else if (op == OP_APPEND)
            begin
                if (key_count >= KeyDepth)
                    status = ST_FULL;
                else
                begin
                    key_time[key_count] = ktime;
                    key_code[key_count] = kcode;
                    key_str[key_count] = kstr;
                    key_count++;
                end
            end
            else if (op == OP_EVAL)
            begin
                if (key_count == 0)
                    status = ST_EMPTY;
                else
                begin
                    t = 0;
                    if (key_time[0] < pos)
                        for (t = 1; t < key_count; t++)
                            if (key_time[t-1] <= pos && pos <= key_time[t]) break;
                    if (t == 0)
                    begin
                        tp = 0; cp = 0; sp = QOne;
                    end
                    else
                    begin
                        tp = key_time[t-1]; cp = key_code[t-1]; sp = key_str[t-1];
                    end
                    if (t >= key_count)
                    begin
                        tn = seq_len; cn = 0; sn = QOne;
                    end
                    else
                    begin
                        tn = key_time[t]; cn = key_code[t]; sn = key_str[t];
                    end
                    f = fraction(pos, tp, tn);
                    if (cp > 12) cp = 12;
                    if (cn > 12) cn = 12;
                    for (ch = 0; ch < 5; ch++)
                    begin
                        s0 = MouthWeight[cp][ch] * sp;
                        s1 = MouthWeight[cn][ch] * sn;
                        acc = s0 * (65536 - f) + s1 * f;
                        r = (acc + (64'd1 << 27)) >> 28;
                        wt[ch] = (r > 65535) ? 16'hFFFF : r[15:0];
                    end
                end
            end
            exp_word = {6'b0, wt[4], wt[3], wt[2], wt[1], wt[0], status};
            blend_q.insert(blend_q.size(), exp_word);
        endfunction

        function void check_word(logic [87:0] w);
            logic [87:0] e;
            string names [6];
            int lo [6];
            int wd [6];
            int i;
            names = '{"status", "weight_a", "weight_e", "weight_ae", "weight_o", "weight_f"};
            lo = '{0, 2, 18, 34, 50, 66};
            wd = '{2, 16, 16, 16, 16, 16};
            if (blend_q.size() == 0)
            begin
                $error("unexpected result word %h", w);
                errors++;
                return;
            end
            e = blend_q.pop_front();
            for (i = 0; i < 6; i++)
                if (((w >> lo[i]) & ((88'd1 << wd[i]) - 1)) !=
                    ((e >> lo[i]) & ((88'd1 << wd[i]) - 1)))
                begin
                    $error("%s: expected %0d, got %0d", names[i],
                           (e >> lo[i]) & ((88'd1 << wd[i]) - 1),
                           (w >> lo[i]) & ((88'd1 << wd[i]) - 1));
                    errors++;
                end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [55:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [87:0] m_axis_tdata;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic        paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    blend_scoreboard sb;
    int  stall_left;
    int  idle_cycles;
    bit  no_gaps;
    int  sent;

    viseme_keyframe_blender_unit u_dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_word(m_axis_tdata);
                stall_left = no_gaps ? 0 : $urandom_range(0, 3);
            end
            else if (stall_left > 0)
                stall_left--;
            m_axis_tready <= (stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
            idle_cycles <= 0;
        else if (idle_cycles >= StallLimit)
        begin
            $display("[viseme_keyframe_blender_unit] ERROR");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_word(op_t op, int ktime, int kcode, int kstr, int pos);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {2'b0, 16'(pos), 16'(kstr), 4'(kcode), 16'(ktime), op};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        sb.note_item(s_axis_tdata);
        sent++;
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.blend_q.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
    endtask

    task automatic write_seq_len(logic [15:0] v);
        drain();
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 1'b0;
        pwdata <= {16'b0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        sb.seq_len = v;
    endtask

    task automatic sorted_run(int keys, int evals);
        int i;
        int t;
        t = $urandom_range(0, 2000);
        send_word(OP_CLEAR, $urandom, $urandom, $urandom, $urandom);
        for (i = 0; i < keys; i++)
        begin
            send_word(OP_APPEND, t, $urandom_range(0, 15),
                      ($urandom_range(0, 7) == 0) ? 65535 : $urandom_range(0, 65535),
                      $urandom);
            t += ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4000);
            if (t > 65535) t = 65535;
        end
        for (i = 0; i < evals; i++)
            send_word(OP_EVAL, $urandom, $urandom, $urandom,
                      ($urandom_range(0, 4) == 0) ? $urandom_range(0, 65535)
                                                  : $urandom_range(0, (t + 2000) % 65536));
    endtask

    initial
    begin
        int i;
        int sel;
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = 1'b0;
        pwdata = '0;
        idle_cycles = 0;
        no_gaps = 1'b0;
        sent = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_seq_len(16'hFFFF);
        send_word(OP_EVAL, 0, 0, 0, 100);
        send_word(OP_NOP, 65535, 15, 65535, 65535);
        send_word(OP_APPEND, 100, 1, int'(QOne), 0);
        send_word(OP_APPEND, 100, 2, 65535, 0);
        send_word(OP_APPEND, 50000, 15, 65535, 0);
        send_word(OP_APPEND, 60000, 6, 0, 0);
        send_word(OP_EVAL, 0, 0, 0, 0);
        send_word(OP_EVAL, 0, 0, 0, 100);
        send_word(OP_EVAL, 0, 0, 0, 30000);
        send_word(OP_EVAL, 0, 0, 0, 55000);
        send_word(OP_EVAL, 0, 0, 0, 65535);
        write_seq_len(16'h0000);
        send_word(OP_EVAL, 0, 0, 0, 65535);
        send_word(OP_CLEAR, 0, 0, 0, 0);
        send_word(OP_APPEND, 500, 7, 32768, 0);
        send_word(OP_APPEND, 100, 10, 4096, 0);
        send_word(OP_APPEND, 400, 11, 8192, 0);
        send_word(OP_EVAL, 0, 0, 0, 300);
        send_word(OP_EVAL, 0, 0, 0, 600);
        send_word(OP_EVAL, 0, 0, 0, 450);
        write_seq_len(16'd1000);
        send_word(OP_EVAL, 0, 0, 0, 800);
        send_word(OP_EVAL, 0, 0, 0, 1200);

        while (sent < 520)
        begin
            if ((sent % 100) < 8)
            begin
                write_seq_len(($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom));
                no_gaps = ($urandom_range(0, 2) == 0);
            end
            sel = $urandom_range(0, 19);
            if (sel == 0)
            begin
                sorted_run(KeyDepth, 3);
                send_word(OP_APPEND, $urandom, $urandom, $urandom, $urandom);
                send_word(OP_EVAL, 0, 0, 0, $urandom);
            end
            else if (sel < 4)
                for (i = 0; i < 6; i++)
                    send_word(op_t'($urandom_range(0, 3)), $urandom, $urandom,
                              $urandom, $urandom);
            else
                sorted_run($urandom_range(1, 8), $urandom_range(1, 6));
        end

        drain();
        if (sb.errors == 0 && sb.blend_q.size() == 0)
            $display("[viseme_keyframe_blender_unit] OK");
        else
            $display("[viseme_keyframe_blender_unit] ERROR");
        $finish;
    end
endmodule
